>>> hw/rtl/cjkseg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cjkseg_pkg
// Shared types, code point constants and the break decision function for the
// CJK sentence segmenter.
// ----------------------------------------------------------------------------
package cjkseg_pkg;

  localparam int CP_W          = 21;
  localparam int RES_PER_GROUP = 3;
  localparam int QUEUE_DEPTH   = 4;

  typedef logic [CP_W-1:0] cp_t;

  // Code points that take part in break decisions
  localparam cp_t CP_TAB         = 21'h00009;
  localparam cp_t CP_NEWLINE     = 21'h0000A;
  localparam cp_t CP_SPACE       = 21'h00020;
  localparam cp_t CP_IDEO_SPACE  = 21'h03000;
  localparam cp_t CP_IDEO_STOP   = 21'h03002;
  localparam cp_t CP_FW_QUESTION = 21'h0FF1F;
  localparam cp_t CP_FW_EXCLAIM  = 21'h0FF01;
  localparam cp_t CP_FW_SEMI     = 21'h0FF1B;
  localparam cp_t CP_FW_COLON    = 21'h0FF1A;
  localparam cp_t CP_FW_COMMA    = 21'h0FF0C;
  localparam cp_t CP_ELLIPSIS    = 21'h02026;

  typedef enum logic [1:0] {
    MODE_BODY  = 2'd0,
    MODE_PUNCT = 2'd1,
    MODE_SPACE = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    BRK_NONE  = 2'd0,
    BRK_PUNCT = 2'd1,
    BRK_SPACE = 2'd2
  } brk_t;

  typedef struct packed {
    cp_t  code_point;
    logic end_of_text;
  } in_item_t;

  typedef struct packed {
    cp_t  out_code_point;
    logic segment_end;
  } out_item_t;

  // One request's worth of results, oldest in slot 0
  typedef struct packed {
    logic [1:0]                    n;
    out_item_t [RES_PER_GROUP-1:0] res;
  } group_t;

  typedef struct packed {
    logic  opens;
    mode_t mode;
    logic  nonempty;
  } decide_t;

  function automatic logic is_run_punct(cp_t c);
    return c == CP_IDEO_STOP || c == CP_FW_QUESTION || c == CP_FW_EXCLAIM ||
           c == CP_FW_SEMI || c == CP_FW_COLON || c == CP_ELLIPSIS ||
           c == CP_FW_COMMA;
  endfunction

  function automatic logic is_space_run(cp_t c);
    return c == CP_SPACE || c == CP_TAB || c == CP_NEWLINE || c == CP_IDEO_SPACE;
  endfunction

  // Decide whether ch opens a new segment, given two code points of lookahead
  function automatic decide_t decide(mode_t mode, logic ne, cp_t ch, cp_t nx, cp_t n2);
    decide_t r;
    brk_t    brk;
    logic    hold;
    r.opens    = 1'b0;
    r.mode     = mode;
    r.nonempty = ne;
    brk        = BRK_NONE;
    hold       = (mode == MODE_PUNCT && is_run_punct(ch)) ||
                 (mode == MODE_SPACE && is_space_run(ch));
    if (!hold) begin
      if (mode != MODE_BODY) begin
        r.mode     = MODE_BODY;
        r.nonempty = 1'b0;
      end
      if (ch == CP_IDEO_STOP || ch == CP_FW_QUESTION || ch == CP_FW_EXCLAIM ||
          ch == CP_ELLIPSIS) begin
        brk = BRK_PUNCT;
      end else if (ch == CP_FW_COMMA && nx == CP_FW_COMMA) begin
        brk = BRK_PUNCT;
      end else if (ch == CP_NEWLINE || ch == CP_TAB) begin
        brk = BRK_SPACE;
      end else if (ch == CP_SPACE || ch == CP_IDEO_SPACE) begin
        if (nx == CP_NEWLINE) begin
          if (n2 == CP_SPACE || n2 == CP_TAB || n2 == CP_NEWLINE) brk = BRK_SPACE;
        end else if (nx == CP_SPACE || nx == CP_TAB) begin
          brk = BRK_SPACE;
        end
      end
      r.opens = !r.nonempty || brk == BRK_SPACE;
      case (brk)
        BRK_PUNCT: r.mode = MODE_PUNCT;
        BRK_SPACE: r.mode = MODE_SPACE;
        default:   r.nonempty = 1'b1;
      endcase
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/cjkseg_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cjkseg_front
// Lookahead window and segment state; decides break flags and turns each
// accepted request into a group of zero to three results.
// ----------------------------------------------------------------------------
module cjkseg_front (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     accept,
  input  cjkseg_pkg::in_item_t    item,
  output logic                    grp_push,
  output cjkseg_pkg::group_t      grp
);

  // Window and segment state
  logic [1:0]          cnt_r, cnt_nxt;
  logic                pvalid_r, pvalid_nxt;
  cjkseg_pkg::mode_t   mode_r, mode_nxt;
  logic                ne_r, ne_nxt;
  cjkseg_pkg::cp_t     la0_r, la0_nxt;
  cjkseg_pkg::cp_t     la1_r, la1_nxt;
  cjkseg_pkg::cp_t     pend_r, pend_nxt;

  logic                eot;
  cjkseg_pkg::cp_t     nx_a;
  cjkseg_pkg::cp_t     n2_a;
  cjkseg_pkg::decide_t d_a;
  cjkseg_pkg::decide_t d_b;
  cjkseg_pkg::out_item_t [2:0] cand;
  logic [2:0]          cand_v;
  logic [1:0]          k;

  assign eot  = item.end_of_text || item.code_point == '0;
  assign nx_a = (!eot || cnt_r == 2'd2) ? la1_r : '0;
  assign n2_a = eot ? '0 : item.code_point;
  assign d_a  = cjkseg_pkg::decide(mode_r, ne_r, la0_r, nx_a, n2_a);
  // second decision of an end-of-text flush with a full window
  assign d_b  = cjkseg_pkg::decide(d_a.mode, d_a.nonempty, la1_r, '0, '0);

  // Candidate results in emit order
  always_comb begin
    cand[0] = '{out_code_point: pend_r, segment_end: d_a.opens};
    cand[1] = '{out_code_point: la0_r, segment_end: 1'b1};
    cand[2] = '{out_code_point: la1_r, segment_end: 1'b1};
    cand_v  = 3'b000;
    if (!eot) begin
      cand_v[0] = pvalid_r && cnt_r == 2'd2;
    end else begin
      case (cnt_r)
        2'd0: begin
          cand[0].segment_end = 1'b1;
          cand_v = {2'b00, pvalid_r};
        end
        2'd1: begin
          cand_v = {2'b01, pvalid_r};
        end
        2'd2: begin
          cand[1].segment_end = d_b.opens;
          cand_v = {2'b11, pvalid_r};
        end
        default: cand_v = 3'b000;
      endcase
    end
  end

  // Pack valid candidates into the low slots
  always_comb begin
    grp = '0;
    k   = 2'd0;
    for (int i = 0; i < cjkseg_pkg::RES_PER_GROUP; i++) begin
      if (cand_v[i]) begin
        grp.res[k] = cand[i];
        k = k + 2'd1;
      end
    end
    grp.n    = k;
    grp_push = accept && k != 2'd0;
  end

  // Next state
  always_comb begin
    cnt_nxt    = cnt_r;
    pvalid_nxt = pvalid_r;
    mode_nxt   = mode_r;
    ne_nxt     = ne_r;
    la0_nxt    = la0_r;
    la1_nxt    = la1_r;
    pend_nxt   = pend_r;
    if (accept) begin
      if (eot) begin
        cnt_nxt    = 2'd0;
        pvalid_nxt = 1'b0;
        mode_nxt   = cjkseg_pkg::MODE_BODY;
        ne_nxt     = 1'b0;
      end else if (cnt_r == 2'd0) begin
        la0_nxt = item.code_point;
        cnt_nxt = 2'd1;
      end else if (cnt_r == 2'd1) begin
        la1_nxt = item.code_point;
        cnt_nxt = 2'd2;
      end else begin
        mode_nxt   = d_a.mode;
        ne_nxt     = d_a.nonempty;
        pend_nxt   = la0_r;
        pvalid_nxt = 1'b1;
        la0_nxt    = la1_r;
        la1_nxt    = item.code_point;
        cnt_nxt    = 2'd2;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      pvalid_r <= 1'b0;
      mode_r   <= cjkseg_pkg::MODE_BODY;
      ne_r     <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      pvalid_r <= pvalid_nxt;
      mode_r   <= mode_nxt;
      ne_r     <= ne_nxt;
    end
  end

  // Held code points
  always_ff @(posedge clk) begin
    la0_r  <= la0_nxt;
    la1_r  <= la1_nxt;
    pend_r <= pend_nxt;
  end

endmodule
`default_nettype wire

>>> hw/rtl/cjkseg_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cjkseg_queue
// Group queue between front and output; hands out one result per pop,
// stepping through the slots of the head group.
// ----------------------------------------------------------------------------
module cjkseg_queue #(
  parameter int DEPTH = cjkseg_pkg::QUEUE_DEPTH
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      push,
  input  cjkseg_pkg::group_t       grp,
  input  wire                      pop,
  output logic                     full,
  output logic                     empty,
  output cjkseg_pkg::out_item_t    result
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cjkseg_pkg::group_t mem [DEPTH];

  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [1:0]    sub_r, sub_nxt;
  logic          do_pop;
  logic          grp_done;

  assign full     = count_r == CW'(DEPTH);
  assign empty    = count_r == '0;
  assign result   = mem[head_r].res[sub_r];
  assign do_pop   = pop && !empty;
  assign grp_done = do_pop && (sub_r + 2'd1) == mem[head_r].n;

  // Pointer and count update
  always_comb begin
    tail_nxt  = tail_r;
    head_nxt  = head_r;
    sub_nxt   = sub_r;
    count_nxt = count_r;
    if (push) begin
      tail_nxt = (tail_r == PW'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
    end
    if (grp_done) begin
      head_nxt = (head_r == PW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
      sub_nxt  = 2'd0;
    end else if (do_pop) begin
      sub_nxt = sub_r + 2'd1;
    end
    if (push && !grp_done) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && grp_done) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      sub_r   <= 2'd0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      sub_r   <= sub_nxt;
    end
  end

  // Group storage
  always_ff @(posedge clk) begin
    if (push) mem[tail_r] <= grp;
  end

endmodule
`default_nettype wire

>>> hw/rtl/cjk_sentence_segmenter_unit.sv
`default_nettype none
// Released results wait in the group queue (QUEUE_DEPTH groups deep) until popped.
// Throughput: one code point per cycle while in_full is low; an end-of-text request
// drains up to three results, one per cycle while popped, from the group queue.
// in_full rises only when the group queue holds QUEUE_DEPTH undelivered groups.
// Reset: synchronous, active low; clears window, segment state and queue pointers.
// ----------------------------------------------------------------------------
// cjk_sentence_segmenter_unit
// Marks the last code point of each sentence or whitespace segment in a CJK
// code point stream.
// ----------------------------------------------------------------------------
module cjk_sentence_segmenter_unit #(
  parameter int QUEUE_DEPTH = cjkseg_pkg::QUEUE_DEPTH
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_push,
  input  cjkseg_pkg::in_item_t     in_item,
  output logic                     in_full,
  input  wire                      out_pop,
  output logic                     out_empty,
  output cjkseg_pkg::out_item_t    out_result
);

  logic               accept;
  logic               grp_push;
  cjkseg_pkg::group_t grp;

  assign accept = in_push && !in_full;

  // Front: window and break decisions
  cjkseg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (in_item),
    .grp_push (grp_push),
    .grp      (grp)
  );

  // Back: group queue and result output
  cjkseg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (grp_push),
    .grp    (grp),
    .pop    (out_pop),
    .full   (in_full),
    .empty  (out_empty),
    .result (out_result)
  );

endmodule
`default_nettype wire

>>> hw/rtl/cjkseg_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cjkseg_checker
// Port-level checks for the segmenter, bound to the top level.
// ----------------------------------------------------------------------------
module cjkseg_checker (
  input wire                      clk,
  input wire                      rst_n,
  input wire                      in_push,
  input wire                      in_full,
  input wire                      out_pop,
  input wire                      out_empty,
  input cjkseg_pkg::out_item_t    out_result
);

  // Nothing comes out right after reset
  a_empty_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> out_empty)
    else $error("result present right after reset");

  // Results only appear after an accepted request
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_empty && !(in_push && !in_full) |=> out_empty)
    else $error("result appeared without an accepted request");

  // Backpressure only while results wait
  a_full_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> !out_empty)
    else $error("input stalled with no result waiting");

  // A waiting result holds until popped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_result))
    else $error("waiting result changed or vanished");

endmodule

bind cjk_sentence_segmenter_unit cjkseg_checker u_cjkseg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_push    (in_push),
  .in_full    (in_full),
  .out_pop    (out_pop),
  .out_empty  (out_empty),
  .out_result (out_result)
);
`default_nettype wire
